>>> hw/rtl/utf8_stream_validator_assert.svh
// assertion macros for the utf8 stream validator
// used by utf8_stream_validator.sv, no other dependencies
`ifndef UTF8_STREAM_VALIDATOR_ASSERT_SVH
`define UTF8_STREAM_VALIDATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define UTF8SV_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define UTF8SV_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/utf8sv_pkg.sv
// constants for the utf8 stream validator: byte classes and owed counts
// no dependencies
package utf8sv_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned OwedWidth = 2;

   // byte class masks and codes
   localparam logic [ByteWidth-1:0] ASCII_MAX  = 8'h7F;
   localparam logic [ByteWidth-1:0] CONT_MASK  = 8'hC0;
   localparam logic [ByteWidth-1:0] CONT_CODE  = 8'h80;
   localparam logic [ByteWidth-1:0] LEAD2_MASK = 8'hE0;
   localparam logic [ByteWidth-1:0] LEAD2_CODE = 8'hC0;
   localparam logic [ByteWidth-1:0] LEAD3_MASK = 8'hF0;
   localparam logic [ByteWidth-1:0] LEAD3_CODE = 8'hE0;
   localparam logic [ByteWidth-1:0] LEAD4_MASK = 8'hF8;
   localparam logic [ByteWidth-1:0] LEAD4_CODE = 8'hF0;

   // surrogate guard: lead 0xED, next byte must not have both 0xA0 bits set
   localparam logic [ByteWidth-1:0] SURR_LEAD  = 8'hED;
   localparam logic [ByteWidth-1:0] SURR_MASK  = 8'hA0;

   // continuation bytes owed after each lead class
   localparam logic [OwedWidth-1:0] OWED_NONE  = 2'd0;
   localparam logic [OwedWidth-1:0] OWED_ONE   = 2'd1;
   localparam logic [OwedWidth-1:0] OWED_TWO   = 2'd2;
   localparam logic [OwedWidth-1:0] OWED_THREE = 2'd3;

endpackage

>>> hw/rtl/utf8_stream_validator.sv
// utf8 stream validator top level: input register, check logic, result register
// depends on utf8sv_pkg and utf8_stream_validator_assert.svh

// Checks UTF-8 framing one byte per request at a sustained rate of one byte
// per clock while the result side is not stalled. A request enters an input
// register; the check logic reads it there together with the string state
// (owed continuation count, sticky error, 0xED mark) and writes the result
// register once the result slot is free. The single state update per cycle
// sets the rate. req_tuser marks the first byte of a new string and clears
// the state before that byte. Overlong encodings are not flagged. Each
// result reports whether the string is still error free and whether it
// would be valid if it ended there.
`include "utf8_stream_validator_assert.svh"

module utf8_stream_validator
   import utf8sv_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   // request channel
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] data_byte
   input  logic       req_tuser,   // [0] first_byte
   // result channel
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata    // [0] no_error_yet, [1] valid_if_end, [7:2] zero
);

   // input register
   logic                 in_valid_ff;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 in_first_ff;

   // string state
   logic [OwedWidth-1:0] owed_ff, owed_in;
   logic                 err_ff, err_in;
   logic                 ed_ff, ed_in;

   // result register
   logic                 rsp_valid_ff;
   logic                 rsp_noerr_ff, rsp_noerr_in;
   logic                 rsp_vend_ff, rsp_vend_in;

   // working copies of the state after an optional clear
   logic [OwedWidth-1:0] owed_cur;
   logic                 err_cur;
   logic                 ed_cur;

   logic                 advance;

   // handshake: move a byte into the result register when the slot is free
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b000000, rsp_vend_ff, rsp_noerr_ff};

   // byte check and next state
   always_comb begin
      owed_cur = in_first_ff ? OWED_NONE : owed_ff;
      err_cur  = in_first_ff ? 1'b0 : err_ff;
      ed_cur   = in_first_ff ? 1'b0 : ed_ff;
      owed_in  = owed_cur;
      err_in   = err_cur;
      ed_in    = ed_cur;
      if (!err_cur) begin
         if (ed_cur && ((in_byte_ff & SURR_MASK) == SURR_MASK)) begin
            err_in = 1'b1;
         end else if (owed_cur != OWED_NONE) begin
            if ((in_byte_ff & CONT_MASK) != CONT_CODE) begin
               err_in = 1'b1;
            end else begin
               owed_in = owed_cur - OWED_ONE;
            end
         end else if (in_byte_ff <= ASCII_MAX) begin
            owed_in = OWED_NONE;
         end else if ((in_byte_ff & LEAD2_MASK) == LEAD2_CODE) begin
            owed_in = OWED_ONE;
         end else if ((in_byte_ff & LEAD3_MASK) == LEAD3_CODE) begin
            owed_in = OWED_TWO;
         end else if ((in_byte_ff & LEAD4_MASK) == LEAD4_CODE) begin
            owed_in = OWED_THREE;
         end else begin
            err_in = 1'b1;
         end
         // mark holds only for the byte right after a 0xED lead
         ed_in = !err_in && (in_byte_ff == SURR_LEAD) && (owed_in == OWED_TWO);
      end
      rsp_noerr_in = !err_in;
      rsp_vend_in  = !err_in && (owed_in == OWED_NONE);
   end

   // input register control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // input register payload
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
      end
   end

   // string state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         owed_ff      <= OWED_NONE;
         err_ff       <= 1'b0;
         ed_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            owed_ff <= owed_in;
            err_ff  <= err_in;
            ed_ff   <= ed_in;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_noerr_ff <= rsp_noerr_in;
         rsp_vend_ff  <= rsp_vend_in;
      end
   end

   // checks
   `UTF8SV_ASSERT_NOW(a_vend_needs_noerr, clock, reset,
      rsp_valid_ff && rsp_vend_ff, rsp_noerr_ff, "valid_if_end without no_error_yet")
   `UTF8SV_ASSERT_NOW(a_ed_mark_owes_two, clock, reset,
      ed_ff && !err_ff, owed_ff == OWED_TWO, "0xED mark without two owed bytes")
   `UTF8SV_ASSERT_NEXT(a_error_sticky, clock, reset, advance && err_ff && !in_first_ff,
      err_ff && !rsp_noerr_ff, "error cleared without a first byte")
   `UTF8SV_ASSERT_NEXT(a_result_after_advance, clock, reset,
      advance, rsp_valid_ff, "advanced byte left no result")

endmodule
